// ----- sv/dd10_pkg.sv -----
// shared types, widths and powers-of-ten table for the decimal divider
`default_nettype none
package dd10_pkg;
  localparam int MAX_DIGITS = 34;
  localparam int DVD_W      = 226;
  localparam int DIV_W      = 113;
  localparam int QUO_W      = 128;
  localparam int POW_W      = 6;
  localparam int IN_W       = 232;
  localparam int OUT_W      = 136;

  localparam logic [1:0] RC_ZERO  = 2'd0;
  localparam logic [1:0] RC_BELOW = 2'd1;
  localparam logic [1:0] RC_HALF  = 2'd2;
  localparam logic [1:0] RC_ABOVE = 2'd3;

  typedef logic [DIV_W-1:0] div_t;
  typedef div_t pow_tab_t [0:MAX_DIGITS];

  // one item in flight through the divider
  typedef struct packed {
    logic              valid;
    logic [DVD_W-1:0]  dvd;
    div_t              div;
    div_t              rem;
    logic [QUO_W-1:0]  quo;
  } dd10_item_t;

  function automatic pow_tab_t make_pow10();
    pow_tab_t t;
    t[0] = div_t'(1);
    for (int k = 1; k <= MAX_DIGITS; k++) begin
      t[k] = div_t'(t[k-1] * div_t'(10));
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = make_pow10();
endpackage
`default_nettype wire

// ----- sv/dd10_stage.sv -----
// one restoring division step with its pipeline register
`default_nettype none
module dd10_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire dd10_pkg::dd10_item_t d,
  output dd10_pkg::dd10_item_t    q
);
  logic [dd10_pkg::DIV_W:0] shifted;
  logic [dd10_pkg::DIV_W+1:0] diff;
  logic take;
  dd10_pkg::dd10_item_t q_next;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {d.rem, d.dvd[dd10_pkg::DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, d.div};
    take    = !diff[dd10_pkg::DIV_W+1];
    q_next.valid = d.valid;
    q_next.dvd   = {d.dvd[dd10_pkg::DVD_W-2:0], 1'b0};
    q_next.div   = d.div;
    q_next.rem   = take ? diff[dd10_pkg::DIV_W-1:0] : shifted[dd10_pkg::DIV_W-1:0];
    q_next.quo   = {d.quo[dd10_pkg::QUO_W-2:0], take};
  end

  // payload moves with the pipeline, valid is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
    if (en) begin
      q.dvd <= q_next.dvd;
      q.div <= q_next.div;
      q.rem <= q_next.rem;
      q.quo <= q_next.quo;
    end
  end
endmodule
`default_nettype wire

// ----- sv/dd10_round.sv -----
// final stage: compare remainder with half the divisor and register the result
`default_nettype none
module dd10_round (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire dd10_pkg::dd10_item_t        d,
  output logic                             valid,
  output logic [dd10_pkg::QUO_W-1:0]       quo,
  output logic [1:0]                       code
);
  dd10_pkg::div_t half;
  logic [1:0] code_next;

  // classify the remainder
  always_comb begin
    half = d.div >> 1;
    if (d.rem == '0) begin
      code_next = dd10_pkg::RC_ZERO;
    end else if (d.rem < half) begin
      code_next = dd10_pkg::RC_BELOW;
    end else if (d.rem == half) begin
      code_next = dd10_pkg::RC_HALF;
    end else begin
      code_next = dd10_pkg::RC_ABOVE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d.valid;
    end
    if (en) begin
      quo  <= d.quo;
      code <= code_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/decimal_divide_by_power_of_ten.sv -----
// Divides a 226-bit unsigned dividend by 10^power and returns the 128-bit
// quotient with a rounding code. Fully pipelined: one beat is accepted per
// cycle unless the output is stalled; each result passes through one input
// register, one restoring division stage per dividend bit, one rounding/output
// register. A power of zero or above 34 divides by one, which passes the low
// 128 bits through with code zero. The whole pipeline stalls together while
// the output beat is held.
`default_nettype none
module decimal_divide_by_power_of_ten (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // dividend_w0[63:0], dividend_w1[127:64], dividend_w2[191:128],
  // dividend_w3[225:192], power[231:226]
  input  wire logic [231:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // quotient_low[63:0], quotient_high[127:64], round_code[129:128], zero pad
  output logic [135:0]     m_tdata
);
  localparam int N = dd10_pkg::DVD_W;

  logic en;
  logic [dd10_pkg::POW_W-1:0] pw;
  dd10_pkg::dd10_item_t pipe [0:N];
  logic [dd10_pkg::QUO_W-1:0] quo;
  logic [1:0] code;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pw       = s_tdata[dd10_pkg::IN_W-1:dd10_pkg::DVD_W];

  // input register with divisor lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0].valid <= s_tvalid;
    end
    if (en) begin
      pipe[0].dvd <= s_tdata[dd10_pkg::DVD_W-1:0];
      pipe[0].rem <= '0;
      pipe[0].quo <= '0;
      if (pw == '0 || pw > dd10_pkg::POW_W'(dd10_pkg::MAX_DIGITS)) begin
        pipe[0].div <= dd10_pkg::POW10[0];
      end else begin
        pipe[0].div <= dd10_pkg::POW10[pw];
      end
    end
  end

  // one division step per dividend bit
  for (genvar i = 0; i < N; i++) begin : g_step
    dd10_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (pipe[i]),
      .q   (pipe[i+1])
    );
  end

  dd10_round u_round (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d     (pipe[N]),
    .valid (m_tvalid),
    .quo   (quo),
    .code  (code)
  );

  assign m_tdata = {6'd0, code, quo};
endmodule
`default_nettype wire

// ----- sv/dd10_checker.sv -----
// port-level checks for the decimal divider
`default_nettype none
module dd10_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [231:0] s_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata
);
  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input is taken whenever the output stage is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free output");

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output beat changed while stalled");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[135:130] == 6'd0))
    else $error("nonzero pad");
endmodule

bind decimal_divide_by_power_of_ten dd10_checker u_dd10_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
